[design/slbm_pkg.sv]
`default_nettype none

package slbm_pkg;

  typedef enum logic [1:0] {
    KIND_TICK    = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_MENU_MAX     = 3'd0,
    REG_ENTER_HOLD   = 3'd1,
    REG_CONFIRM_HOLD = 3'd2,
    REG_IDLE_LIMIT   = 3'd3,
    REG_BEAT_HALF    = 3'd4,
    REG_FLASH_HALF   = 3'd5,
    REG_FLASH_GAP    = 3'd6,
    REG_SPARE        = 3'd7
  } reg_index_t;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned HoldW  = 16;
  localparam int unsigned ValueW = 8;
  localparam int unsigned CfgW   = 16;

  localparam logic [ValueW-1:0] MenuMaxReset     = 8'd1;
  localparam logic [HoldW-1:0]  EnterHoldReset   = 16'd1000;
  localparam logic [HoldW-1:0]  ConfirmHoldReset = 16'd2000;
  localparam logic [HoldW-1:0]  IdleLimitReset   = 16'd10000;
  localparam logic [HoldW-1:0]  BeatHalfReset    = 16'd500;
  localparam logic [HoldW-1:0]  FlashHalfReset   = 16'd250;
  localparam logic [HoldW-1:0]  FlashGapReset    = 16'd1000;
  localparam logic [ValueW-1:0] SelectionReset   = 8'd1;

endpackage

`default_nettype wire

[design/status_led_button_menu.sv]
`default_nettype none

// One-button status LED controller. Each input transfer is a service tick or a
// button press/release (kind in s_tuser, time and hold duration in s_tdata) and
// yields exactly one result transfer with the LED state, mode, a publish flag
// and the current selection. An item is held in the input register and is then
// evaluated against the controller state in one pass into the result register;
// one item is accepted every cycle, and the only limit on rate is output
// backpressure, which holds the result register and then also a full input register.
// Configuration writes take effect on the next item and are meant for idle
// periods; times already scheduled are kept.
module status_led_button_menu (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [31:0] time_ms, [63:32] hold_ms
  input  wire logic [1:0]  s_tuser,   // [1:0] kind
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [0] led_lit, [1] in_menu, [9:2] choice_value
  output logic [0:0]       m_tuser    // [0] choice_valid
);
  import slbm_pkg::*;

  // configuration registers
  logic [ValueW-1:0] menu_max;
  logic [HoldW-1:0]  enter_hold;
  logic [HoldW-1:0]  confirm_hold;
  logic [HoldW-1:0]  idle_limit;
  logic [HoldW-1:0]  beat_half;
  logic [HoldW-1:0]  flash_half;
  logic [HoldW-1:0]  flash_gap;

  always_ff @(posedge clk) begin
    if (rst) begin
      menu_max     <= MenuMaxReset;
      enter_hold   <= EnterHoldReset;
      confirm_hold <= ConfirmHoldReset;
      idle_limit   <= IdleLimitReset;
      beat_half    <= BeatHalfReset;
      flash_half   <= FlashHalfReset;
      flash_gap    <= FlashGapReset;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MENU_MAX:     menu_max     <= cfg_data[ValueW-1:0];
        REG_ENTER_HOLD:   enter_hold   <= cfg_data;
        REG_CONFIRM_HOLD: confirm_hold <= cfg_data;
        REG_IDLE_LIMIT:   idle_limit   <= cfg_data;
        REG_BEAT_HALF:    beat_half    <= cfg_data;
        REG_FLASH_HALF:   flash_half   <= cfg_data;
        REG_FLASH_GAP:    flash_gap    <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic             in_valid;
  kind_t            in_kind;
  logic [TimeW-1:0] in_time;
  logic [TimeW-1:0] in_hold;
  logic             advance;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_kind <= kind_t'(s_tuser);
      in_time <= s_tdata[31:0];
      in_hold <= s_tdata[63:32];
    end
  end

  // controller state
  logic              mode;
  logic [TimeW-1:0]  next_change;
  logic [TimeW-1:0]  last_activity;
  logic [ValueW-1:0] selection;
  logic [ValueW-1:0] flash_count;
  logic              led_state;

  logic              mode_next;
  logic [TimeW-1:0]  next_change_next;
  logic [TimeW-1:0]  last_activity_next;
  logic [ValueW-1:0] selection_next;
  logic [ValueW-1:0] flash_count_next;
  logic              led_state_next;
  logic              valid_next;

  logic [TimeW-1:0]  since_change;
  logic [TimeW-1:0]  since_activity;
  logic              due;
  logic              idle_out;
  logic              long_hold;
  logic              confirm;
  logic [ValueW-1:0] count_inc;

  assign since_change   = in_time - next_change;
  assign since_activity = in_time - last_activity;
  // due when the target is less than half the wrap range behind now
  assign due       = !since_change[TimeW-1];
  assign idle_out  = since_activity >= {{(TimeW-HoldW){1'b0}}, idle_limit};
  assign long_hold = in_hold >= {{(TimeW-HoldW){1'b0}}, enter_hold};
  assign confirm   = in_hold >= {{(TimeW-HoldW){1'b0}}, confirm_hold};
  assign count_inc = flash_count + 8'd1;

  always_comb begin
    mode_next          = mode;
    next_change_next   = next_change;
    last_activity_next = last_activity;
    selection_next     = selection;
    flash_count_next   = flash_count;
    led_state_next     = led_state;
    valid_next         = 1'b0;
    case (in_kind)
      KIND_TICK: begin
        if (!mode) begin
          if (due) begin
            led_state_next   = !led_state;
            next_change_next = in_time + {{(TimeW-HoldW){1'b0}}, beat_half};
          end
        end else if (idle_out) begin
          mode_next        = 1'b0;
          led_state_next   = 1'b0;
          next_change_next = in_time + {{(TimeW-HoldW){1'b0}}, beat_half};
        end else if (due) begin
          if (!led_state) begin
            led_state_next   = 1'b1;
            next_change_next = in_time + {{(TimeW-HoldW){1'b0}}, flash_half};
          end else begin
            led_state_next = 1'b0;
            // end of a run of flashes: start the gap
            if (count_inc >= selection) begin
              flash_count_next = '0;
              next_change_next = in_time + {{(TimeW-HoldW){1'b0}}, flash_gap};
            end else begin
              flash_count_next = count_inc;
              next_change_next = in_time + {{(TimeW-HoldW){1'b0}}, flash_half};
            end
          end
        end
      end
      KIND_PRESS: begin
        if (mode) begin
          last_activity_next = in_time;
        end
      end
      KIND_RELEASE: begin
        if (!mode) begin
          if (long_hold) begin
            mode_next          = 1'b1;
            last_activity_next = in_time;
            selection_next     = SelectionReset;
            flash_count_next   = '0;
            led_state_next     = 1'b0;
            next_change_next   = in_time;
          end
        end else begin
          last_activity_next = in_time;
          if (confirm) begin
            valid_next       = 1'b1;
            mode_next        = 1'b0;
            led_state_next   = 1'b0;
            next_change_next = in_time + {{(TimeW-HoldW){1'b0}}, beat_half};
          end else if (!long_hold) begin
            selection_next   = (selection >= menu_max) ? SelectionReset
                                                       : selection + 8'd1;
            flash_count_next = '0;
            led_state_next   = 1'b0;
            next_change_next = in_time;
          end
        end
      end
      default: ;
    endcase
  end

  logic step;
  assign step = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= 1'b0;
      next_change   <= {{(TimeW-HoldW){1'b0}}, BeatHalfReset};
      last_activity <= '0;
      selection     <= SelectionReset;
      flash_count   <= '0;
      led_state     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (step) begin
        mode          <= mode_next;
        next_change   <= next_change_next;
        last_activity <= last_activity_next;
        selection     <= selection_next;
        flash_count   <= flash_count_next;
        led_state     <= led_state_next;
      end
      if (advance) begin
        m_tvalid <= in_valid;
      end
    end
    if (step) begin
      m_tdata <= {6'd0, selection_next, mode_next, led_state_next};
      m_tuser <= valid_next;
    end
  end

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import slbm_pkg::*;

  typedef struct packed {
    logic       led_lit;
    logic       in_menu;
    logic       choice_valid;
    logic [7:0] choice_value;
  } led_status_t;

  // Tracks the controller state, predicts one status per input transfer and
  // checks result transfers in order against those predictions.
  class led_menu_scoreboard;
    logic [7:0]  menu_max;
    logic [15:0] enter_hold;
    logic [15:0] confirm_hold;
    logic [15:0] idle_limit;
    logic [15:0] beat_half;
    logic [15:0] flash_half;
    logic [15:0] flash_gap;

    logic        menu_mode;
    logic        led_on;
    logic [31:0] next_change;
    logic [31:0] last_activity;
    logic [7:0]  selection;
    logic [7:0]  flash_count;

    led_status_t expected_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned published;
    int unsigned menu_entries;
    int unsigned kind_count[4];

    function new();
      menu_max      = MenuMaxReset;
      enter_hold    = EnterHoldReset;
      confirm_hold  = ConfirmHoldReset;
      idle_limit    = IdleLimitReset;
      beat_half     = BeatHalfReset;
      flash_half    = FlashHalfReset;
      flash_gap     = FlashGapReset;
      menu_mode     = 1'b0;
      led_on        = 1'b0;
      next_change   = BeatHalfReset;
      last_activity = '0;
      selection     = SelectionReset;
      flash_count   = '0;
      errors        = 0;
      checked       = 0;
      published     = 0;
      menu_entries  = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [15:0] value);
      case (idx)
        REG_MENU_MAX:     menu_max = value[7:0];
        REG_ENTER_HOLD:   enter_hold = value;
        REG_CONFIRM_HOLD: confirm_hold = value;
        REG_IDLE_LIMIT:   idle_limit = value;
        REG_BEAT_HALF:    beat_half = value;
        REG_FLASH_HALF:   flash_half = value;
        REG_FLASH_GAP:    flash_gap = value;
        default: ;
      endcase
    endfunction

    // wrap-safe: target counts as reached when less than half the 32-bit range behind now
    function bit reached(logic [31:0] now, logic [31:0] target);
      logic [31:0] diff;
      diff = now - target;
      return !diff[31];
    endfunction

    function void to_heartbeat(logic [31:0] now);
      menu_mode   = 1'b0;
      led_on      = 1'b0;
      next_change = now + beat_half;
    endfunction

    function void serve_flash(logic [31:0] now);
      if (!reached(now, next_change)) return;
      if (!led_on) begin
        led_on      = 1'b1;
        next_change = now + flash_half;
        return;
      end
      led_on      = 1'b0;
      flash_count = flash_count + 8'd1;
      if (flash_count >= selection) begin
        flash_count = '0;
        next_change = now + flash_gap;
      end else begin
        next_change = now + flash_half;
      end
    endfunction

    function void note_event(kind_t kind, logic [31:0] now, logic [31:0] hold);
      led_status_t st;
      logic [31:0] idle_for;
      st.choice_valid = 1'b0;
      kind_count[kind]++;
      case (kind)
        KIND_TICK: begin
          idle_for = now - last_activity;
          if (!menu_mode) begin
            if (reached(now, next_change)) begin
              led_on      = !led_on;
              next_change = now + beat_half;
            end
          end else if (idle_for >= idle_limit) begin
            to_heartbeat(now);
          end else begin
            serve_flash(now);
          end
        end
        KIND_PRESS: begin
          if (menu_mode) last_activity = now;
        end
        KIND_RELEASE: begin
          if (!menu_mode) begin
            if (hold >= enter_hold) begin
              menu_mode     = 1'b1;
              last_activity = now;
              selection     = 8'd1;
              flash_count   = '0;
              led_on        = 1'b0;
              next_change   = now;
              menu_entries++;
            end
          end else begin
            last_activity = now;
            // confirm wins when the two hold windows overlap
            if (hold >= confirm_hold) begin
              st.choice_valid = 1'b1;
              published++;
              to_heartbeat(now);
            end else if (hold < enter_hold) begin
              selection   = (selection >= menu_max) ? 8'd1 : selection + 8'd1;
              flash_count = '0;
              led_on      = 1'b0;
              next_change = now;
            end
          end
        end
        default: ;
      endcase
      st.led_lit      = led_on;
      st.in_menu      = menu_mode;
      st.choice_value = selection;
      expected_q.push_back(st);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_status(logic [15:0] data, logic [0:0] user);
      led_status_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual data %h user %b",
                 $time, data, user);
        return;
      end
      want = expected_q.pop_front();
      compare_field("led_lit", want.led_lit, data[0]);
      compare_field("in_menu", want.in_menu, data[1]);
      compare_field("choice_value", want.choice_value, data[9:2]);
      compare_field("choice_valid", want.choice_valid, user[0]);
    endfunction
  endclass

  localparam int unsigned WatchdogLimit = 4000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  reg_index_t  cfg_index = REG_MENU_MAX;
  logic [15:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;   // [31:0] time_ms, [63:32] hold_ms
  logic [1:0]  s_tuser = KIND_TICK;  // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [0] led_lit, [1] in_menu, [9:2] choice_value
  logic [0:0]  m_tuser;        // [0] choice_valid

  led_menu_scoreboard sb = new();

  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned sent_items = 0;
  int unsigned quiet_cycles = 0;
  int unsigned settings_run = 0;
  logic [31:0] now_ms = '0;

  status_led_button_menu dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_event(kind_t'(s_tuser), s_tdata[31:0], s_tdata[63:32]);
      if (m_tvalid && m_tready) sb.check_status(m_tdata, m_tuser);
    end
  end

  always @(negedge clk) begin
    m_tready <= (stall_pct == 0) || ($urandom_range(99, 0) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("status_led_button_menu test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Entered and left at a falling edge; valid stays high into the next call.
  task automatic send_event(kind_t kind, logic [31:0] t, logic [31:0] hold);
    while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {hold, t};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_hold(int unsigned step);
    int unsigned r;
    logic [31:0] lo;
    logic [31:0] hi;
    r = $urandom_range(99, 0);
    if (r < 45) begin
      // short release: advances the selection
      return (sb.enter_hold == 0) ? 32'd0 : $urandom_range(sb.enter_hold - 1, 0);
    end else if (r < 60) begin
      lo = sb.enter_hold;
      hi = (sb.confirm_hold > sb.enter_hold) ? sb.confirm_hold - 1 : sb.enter_hold;
      return $urandom_range(hi, lo);
    end else if (r < 90) begin
      return sb.confirm_hold + $urandom_range(step, 0);
    end
    return $urandom;
  endfunction

  task automatic run_phase(logic [7:0] mm, logic [15:0] eh, logic [15:0] ch,
                           logic [15:0] il, logic [15:0] bh, logic [15:0] fh,
                           logic [15:0] fg, int unsigned step, logic [31:0] start,
                           int unsigned idling, int unsigned n_items);
    int unsigned target;
    int unsigned r;
    int unsigned n_ticks;
    logic [31:0] pressed_at;
    logic [31:0] hold;
    settle();
    write_reg(REG_MENU_MAX, {8'd0, mm});
    write_reg(REG_ENTER_HOLD, eh);
    write_reg(REG_CONFIRM_HOLD, ch);
    write_reg(REG_IDLE_LIMIT, il);
    write_reg(REG_BEAT_HALF, bh);
    write_reg(REG_FLASH_HALF, fh);
    write_reg(REG_FLASH_GAP, fg);
    cfg_we <= 1'b0;
    settings_run++;
    send_gap_pct = (idling == 1) ? 48 : (idling == 3) ? 17 : 0;
    stall_pct    = (idling == 2) ? 48 : (idling == 3) ? 17 : 0;
    now_ms = start;
    target = sent_items + n_items;
    while (sent_items < target) begin
      r = $urandom_range(99, 0);
      if (r < 75) begin
        // press, a few ticks while held, release, then ticks to watch the LED
        pressed_at = now_ms;
        hold = pick_hold(step);
        send_event(KIND_PRESS, pressed_at, $urandom);
        n_ticks = $urandom_range(2, 0);
        repeat (n_ticks) send_event(KIND_TICK, pressed_at + $urandom_range(hold, 0), $urandom);
        now_ms = pressed_at + hold;
        send_event(KIND_RELEASE, now_ms, hold);
        n_ticks = $urandom_range(6, 1);
        repeat (n_ticks) begin
          now_ms = now_ms + $urandom_range(step, 1);
          send_event(KIND_TICK, now_ms, $urandom);
        end
      end else if (r < 90) begin
        // long quiet stretch, may run into the idle timeout
        now_ms = now_ms + $urandom_range(2 * sb.idle_limit + step, 0);
        send_event(KIND_TICK, now_ms, $urandom);
      end else if (r < 98) begin
        now_ms = now_ms + $urandom_range(step, 0);
        send_event(kind_t'($urandom_range(3, 0)), now_ms, $urandom);
      end else begin
        send_event(kind_t'($urandom_range(3, 0)), $urandom, $urandom);
      end
    end
  endtask

  task automatic directed_checks();
    logic [31:0] t;
    t = 32'h8000_03E7;
    send_event(KIND_TICK, 32'd0, 32'd0);
    send_event(KIND_TICK, 32'd499, 32'hFFFF_FFFF);
    send_event(KIND_TICK, 32'd500, 32'd0);
    // exactly half the counter range past the target: not yet reached
    send_event(KIND_TICK, 32'h8000_03E8, 32'd0);
    send_event(KIND_TICK, t, 32'd0);
    send_event(KIND_PRESS, t + 10, 32'd0);
    send_event(KIND_RELEASE, t + 20, 32'd999);
    send_event(KIND_UNUSED, t + 30, 32'hFFFF_FFFF);
    send_event(KIND_RELEASE, t + 40, 32'd1000);
    send_event(KIND_TICK, t + 40, 32'd0);
    send_event(KIND_TICK, t + 290, 32'd0);
    send_event(KIND_PRESS, t + 300, 32'd0);
    send_event(KIND_RELEASE, t + 1800, 32'd1500);
    send_event(KIND_RELEASE, t + 1900, 32'd0);
    send_event(KIND_TICK, t + 11899, 32'd0);
    send_event(KIND_TICK, t + 11900, 32'd0);
    send_event(KIND_RELEASE, t + 12000, 32'hFFFF_FFFF);
    send_event(KIND_RELEASE, t + 12100, 32'd2000);
    send_event(KIND_RELEASE, t + 12200, 32'd1999);
    send_event(KIND_TICK, t + 12200, 32'd0);
    send_event(KIND_RELEASE, t + 12300, 32'hFFFF_FFFF);
    send_event(KIND_TICK, 32'hFFFF_FFFF, 32'd0);
    send_event(KIND_TICK, 32'd0, 32'hFFFF_FFFF);
    send_event(KIND_TICK, 32'd600, 32'd0);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_checks();
    run_phase(8'd1, 16'd1000, 16'd2000, 16'd10000, 16'd500, 16'd250, 16'd1000,
              400, 32'd100_000, 0, 230);
    run_phase(8'd5, 16'd100, 16'd300, 16'd2000, 16'd50, 16'd20, 16'd80,
              60, 32'hFFFF_F000, 1, 230);
    run_phase(8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              30000, 32'h1234_0000, 2, 230);
    run_phase(8'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
              5, 32'h0000_0100, 3, 230);
    // confirm shorter than enter: overlapping hold windows
    run_phase(8'd3, 16'd500, 16'd200, 16'd3000, 16'd100, 16'd30, 16'd150,
              80, 32'h7FFF_FF00, 0, 230);
    run_phase(8'd8, 16'd60, 16'd400, 16'd1500, 16'd40, 16'd10, 16'd60,
              40, 32'hFFFF_FF80, 1, 230);
    run_phase(8'd2, 16'd1, 16'hFFFF, 16'd800, 16'd1, 16'd1, 16'd1,
              3, 32'h8000_0000, 2, 230);
    settle();
    $display("Sent %0d events (%0d ticks, %0d presses, %0d releases, %0d unused kind)",
             sent_items, sb.kind_count[KIND_TICK], sb.kind_count[KIND_PRESS],
             sb.kind_count[KIND_RELEASE], sb.kind_count[KIND_UNUSED]);
    $display("%0d results checked over %0d register settings, %0d menu entries, %0d published",
             sb.checked, settings_run, sb.menu_entries, sb.published);
    if (sb.expected_q.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, sb.expected_q.size());
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("status_led_button_menu test passed");
    end else begin
      $display("status_led_button_menu test failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/slbm_pkg.sv
design/status_led_button_menu.sv
bench/testbench.sv
